/* sv/vad_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vad_pkg
// types, constants and tables shared by the angular distance block
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 64;

  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned ANGLE_W   = 15;
  localparam int unsigned FRAC_SH   = 20;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned RT_W      = SQ_W / 2;
  localparam int unsigned REM_W     = RT_W + 4;
  localparam int unsigned C_W       = 30;
  localparam int unsigned COR_W     = 34;
  localparam int unsigned Z_W       = 24;
  localparam int unsigned ZU_W      = 22;
  localparam int unsigned ATAN_W    = 20;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned SQ_STEPS  = RT_W;
  localparam int unsigned DIV_STEPS = C_W;
  localparam int unsigned COR_STEPS = 21;

  localparam logic [ANGLE_W-1:0] PI_Q13      = 15'd25736;
  localparam logic [ANGLE_W-1:0] LIMIT_RESET = 15'd25736;
  localparam logic [ZU_W-1:0]    PI_Q20      = 22'd3294199;
  localparam logic [ZU_W-1:0]    HALF_PI_Q20 = 22'd1647099;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     last;
  } vad_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               is_neighbour;
    logic               zero_norm;
  } vad_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_CHECK,
    ST_SQA,
    ST_SQB_LD,
    ST_SQB,
    ST_MUL_D,
    ST_CMP,
    ST_DIV,
    ST_MUL_C,
    ST_SQS_LD,
    ST_SQS,
    ST_COR_LD,
    ST_COR,
    ST_DONE
  } vad_state_e;

  typedef enum logic [1:0] {
    SQ_A,
    SQ_B,
    SQ_S
  } vad_sq_sel_e;

  typedef enum logic [1:0] {
    RES_ANGLE,
    RES_ZERO,
    RES_SAT
  } vad_res_kind_e;

  typedef struct packed {
    logic          take;
    logic          acc_clr;
    logic          sq_load;
    vad_sq_sel_e   sq_sel;
    logic          sq_step;
    logic          ra_load;
    logic          d_load;
    logic          div_init;
    logic          div_step;
    logic          cc_load;
    logic          cor_init;
    logic          cor_step;
    logic          res_load;
    vad_res_kind_e res_kind;
    logic [IDX_W-1:0] idx;
  } vad_cmd_t;

  typedef struct packed {
    logic zero;
    logic sat;
  } vad_sts_t;

  function automatic logic [ATAN_W-1:0] atan_q20(input logic [IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/vad_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vad_isqrt
// digit-by-digit integer square root, one root bit per step
// ----------------------------------------------------------------------------
module vad_isqrt (
  input  wire                          clk_i,
  input  wire                          load_i,
  input  wire                          step_i,
  input  wire  [vad_pkg::SQ_W-1:0]     radicand_i,
  output logic [vad_pkg::RT_W-1:0]     root_o
);
  import vad_pkg::*;

  logic [SQ_W-1:0]  rad_q;
  logic [REM_W-1:0] rem_q;
  logic [RT_W-1:0]  root_q;
  logic [REM_W-1:0] cand;
  logic [REM_W-1:0] trial;

  assign cand   = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      rad_q <= {rad_q[SQ_W-3:0], 2'b00};
      if (cand >= trial) begin
        rem_q  <= cand - trial;
        root_q <= {root_q[RT_W-2:0], 1'b1};
      end else begin
        rem_q  <= cand;
        root_q <= {root_q[RT_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* sv/vad_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vad_datapath
// accumulators, root/divide/cordic registers and the result register
// ----------------------------------------------------------------------------
module vad_datapath #(
  parameter int unsigned MAX_LENGTH = vad_pkg::MAX_LENGTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  vad_pkg::vad_cmd_t            cmd_i,
  input  vad_pkg::vad_in_t             in_item_i,
  input  wire                          cfg_we_i,
  input  wire  [vad_pkg::ANGLE_W-1:0]  cfg_wdata_i,
  output vad_pkg::vad_sts_t            sts_o,
  output vad_pkg::vad_out_t            out_item_o
);
  import vad_pkg::*;

  localparam int unsigned NORM_W = 30 + $clog2(MAX_LENGTH + 1);
  localparam int unsigned DOT_W  = NORM_W + 1;

  logic signed [2*ELEM_W-1:0] prod_ab, prod_aa, prod_bb;
  logic signed [2*ELEM_W-1:0] pd_q;
  logic [2*ELEM_W-2:0]        pa_q, pb_q;
  logic                       pv_q;
  logic signed [DOT_W-1:0]    dot_q;
  logic [NORM_W-1:0]          na_q, nb_q;
  logic [ANGLE_W-1:0]         limit_q;

  logic [SQ_W-1:0]  radicand;
  logic [RT_W-1:0]  root;
  logic [RT_W-1:0]  ra_q;
  logic [SQ_W-1:0]  d_q;
  logic             neg;
  logic [DOT_W-1:0] mag;
  logic [SQ_W-1:0]  n_val;
  logic [SQ_W-1:0]  r_q;
  logic [SQ_W-1:0]  r_sh;
  logic [C_W-1:0]   c_q;
  logic [2*C_W-1:0] cc_q;

  logic signed [COR_W-1:0] x_q, y_q, ax, ay, dx, dy;
  logic signed [Z_W-1:0]   z_q, at;
  logic [ZU_W-1:0]         zc, zf;
  logic [ZU_W:0]           zr;
  logic [ANGLE_W-1:0]      ang_cor, angle;
  vad_out_t                res_q;

  assign prod_ab = in_item_i.a_elem * in_item_i.b_elem;
  assign prod_aa = in_item_i.a_elem * in_item_i.a_elem;
  assign prod_bb = in_item_i.b_elem * in_item_i.b_elem;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pd_q <= prod_ab;
      pa_q <= prod_aa[2*ELEM_W-2:0];
      pb_q <= prod_bb[2*ELEM_W-2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      dot_q   <= '0;
      na_q    <= '0;
      nb_q    <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      pv_q <= cmd_i.take;
      if (cmd_i.acc_clr) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
      end else if (pv_q) begin
        dot_q <= dot_q + DOT_W'(pd_q);
        na_q  <= na_q + NORM_W'(pa_q);
        nb_q  <= nb_q + NORM_W'(pb_q);
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    case (cmd_i.sq_sel)
      SQ_A:    radicand = SQ_W'({na_q, {FRAC_SH{1'b0}}});
      SQ_B:    radicand = SQ_W'({nb_q, {FRAC_SH{1'b0}}});
      SQ_S:    radicand = (SQ_W'(1) << 60) - SQ_W'(cc_q);
      default: radicand = '0;
    endcase
  end

  vad_isqrt u_isqrt (
    .clk_i      (clk_i),
    .load_i     (cmd_i.sq_load),
    .step_i     (cmd_i.sq_step),
    .radicand_i (radicand),
    .root_o     (root)
  );

  assign neg   = dot_q[DOT_W-1];
  assign mag   = neg ? DOT_W'(-dot_q) : DOT_W'(dot_q);
  assign n_val = SQ_W'({mag, {FRAC_SH{1'b0}}});
  assign r_sh  = {r_q[SQ_W-2:0], 1'b0};

  assign sts_o.zero = (na_q == '0) || (nb_q == '0);
  assign sts_o.sat  = n_val >= d_q;

  // cordic shifts truncate toward zero
  assign ax = y_q[COR_W-1] ? -y_q : y_q;
  assign ay = x_q[COR_W-1] ? -x_q : x_q;
  assign dx = y_q[COR_W-1] ? -(ax >>> cmd_i.idx) : (ax >>> cmd_i.idx);
  assign dy = x_q[COR_W-1] ? -(ay >>> cmd_i.idx) : (ay >>> cmd_i.idx);
  assign at = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q20(cmd_i.idx)});

  always_ff @(posedge clk_i) begin
    if (cmd_i.ra_load) begin
      ra_q <= root;
    end
    if (cmd_i.d_load) begin
      d_q <= ra_q * root;
    end
    if (cmd_i.div_init) begin
      r_q <= n_val;
      c_q <= '0;
    end else if (cmd_i.div_step) begin
      if (r_sh >= d_q) begin
        r_q <= r_sh - d_q;
        c_q <= {c_q[C_W-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        c_q <= {c_q[C_W-2:0], 1'b0};
      end
    end
    if (cmd_i.cc_load) begin
      cc_q <= c_q * c_q;
    end
    if (cmd_i.cor_init) begin
      x_q <= $signed(COR_W'(c_q));
      y_q <= $signed(COR_W'(root));
      z_q <= '0;
    end else if (cmd_i.cor_step) begin
      if (!y_q[COR_W-1] && (y_q != '0)) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end else if (y_q[COR_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end
    end
    if (cmd_i.res_load) begin
      res_q.angle        <= angle;
      res_q.is_neighbour <= (cmd_i.res_kind != RES_ZERO) && (angle <= limit_q);
      res_q.zero_norm    <= (cmd_i.res_kind == RES_ZERO);
    end
  end

  always_comb begin
    if (z_q[Z_W-1]) begin
      zc = '0;
    end else if (z_q > $signed(Z_W'(HALF_PI_Q20))) begin
      zc = HALF_PI_Q20;
    end else begin
      zc = z_q[ZU_W-1:0];
    end
    zf = neg ? (PI_Q20 - zc) : zc;
    zr = (ZU_W+1)'(zf) + (ZU_W+1)'(64);
    if (zr[ZU_W:7] > (ZU_W-6)'(PI_Q13)) begin
      ang_cor = PI_Q13;
    end else begin
      ang_cor = zr[ANGLE_W+6:7];
    end
    case (cmd_i.res_kind)
      RES_ANGLE: angle = ang_cor;
      RES_ZERO:  angle = '0;
      RES_SAT:   angle = neg ? PI_Q13 : '0;
      default:   angle = '0;
    endcase
  end

  assign out_item_o = res_q;

endmodule
`default_nettype wire

/* sv/vad_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vad_ctrl
// sequencer for accumulation and the final angle computation
// ----------------------------------------------------------------------------
module vad_ctrl #(
  parameter int unsigned MAX_LENGTH = vad_pkg::MAX_LENGTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                last_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  input  vad_pkg::vad_sts_t  sts_i,
  output vad_pkg::vad_cmd_t  cmd_o
);
  import vad_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);

  vad_state_e       state_q, state_d;
  vad_res_kind_e    kind_q;
  logic [IDX_W-1:0] cnt_q;
  logic [CNT_W-1:0] elem_q;
  logic             out_valid_q;
  logic             take, fin, free, stepping, step_last;

  assign take = in_valid_i && (state_q == ST_IDLE);
  assign fin  = last_i || (elem_q == CNT_W'(MAX_LENGTH - 1));
  assign free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (state_q)
      ST_SQA, ST_SQB, ST_SQS: begin
        stepping  = 1'b1;
        step_last = (cnt_q == IDX_W'(SQ_STEPS - 1));
      end
      ST_DIV: begin
        stepping  = 1'b1;
        step_last = (cnt_q == IDX_W'(DIV_STEPS - 1));
      end
      ST_COR: begin
        stepping  = 1'b1;
        step_last = (cnt_q == IDX_W'(COR_STEPS - 1));
      end
      default: begin
        stepping  = 1'b0;
        step_last = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (take && fin) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.zero ? ST_DONE : ST_SQA;
      ST_SQA:    if (step_last) state_d = ST_SQB_LD;
      ST_SQB_LD: state_d = ST_SQB;
      ST_SQB:    if (step_last) state_d = ST_MUL_D;
      ST_MUL_D:  state_d = ST_CMP;
      ST_CMP:    state_d = sts_i.sat ? ST_DONE : ST_DIV;
      ST_DIV:    if (step_last) state_d = ST_MUL_C;
      ST_MUL_C:  state_d = ST_SQS_LD;
      ST_SQS_LD: state_d = ST_SQS;
      ST_SQS:    if (step_last) state_d = ST_COR_LD;
      ST_COR_LD: state_d = ST_COR;
      ST_COR:    if (step_last) state_d = ST_DONE;
      ST_DONE:   if (free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.sq_sel   = SQ_A;
    cmd_o.res_kind = kind_q;
    cmd_o.idx      = cnt_q;
    cmd_o.take     = take;
    in_stall_o     = (state_q != ST_IDLE);
    out_valid_o    = out_valid_q;
    case (state_q)
      ST_CHECK: begin
        cmd_o.sq_load = 1'b1;
        cmd_o.sq_sel  = SQ_A;
      end
      ST_SQA, ST_SQB, ST_SQS: cmd_o.sq_step = 1'b1;
      ST_SQB_LD: begin
        cmd_o.ra_load = 1'b1;
        cmd_o.sq_load = 1'b1;
        cmd_o.sq_sel  = SQ_B;
      end
      ST_MUL_D:  cmd_o.d_load   = 1'b1;
      ST_CMP:    cmd_o.div_init = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_MUL_C:  cmd_o.cc_load  = 1'b1;
      ST_SQS_LD: begin
        cmd_o.sq_load = 1'b1;
        cmd_o.sq_sel  = SQ_S;
      end
      ST_COR_LD: cmd_o.cor_init = 1'b1;
      ST_COR:    cmd_o.cor_step = 1'b1;
      ST_DONE: begin
        cmd_o.res_load = free;
        cmd_o.acc_clr  = free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= RES_ANGLE;
      cnt_q       <= '0;
      elem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (stepping && !step_last) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (take) begin
        elem_q <= fin ? '0 : elem_q + 1'b1;
      end
      if (state_q == ST_CHECK) begin
        kind_q <= sts_i.zero ? RES_ZERO : RES_ANGLE;
      end else if ((state_q == ST_CMP) && sts_i.sat) begin
        kind_q <= RES_SAT;
      end
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/vector_angular_distance.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_angular_distance
// angle between two streamed vectors via cosine similarity and arccosine
// ----------------------------------------------------------------------------
// non-final item: taken back to back
// final item: result from the shared 32-step root unit, 30-step divider and
//   21-step cordic (a zero vector skips all three; when |cos| clamps to 1 the
//   third root, divider and cordic are skipped); input stalls until it is loaded
// reset clears accumulators and output valid, limit returns to pi
// ----------------------------------------------------------------------------
module vector_angular_distance #(
  parameter int unsigned MAX_LENGTH = vad_pkg::MAX_LENGTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  vad_pkg::vad_in_t             in_item_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output vad_pkg::vad_out_t            out_item_o,
  input  wire                          cfg_we_i,
  input  wire  [vad_pkg::ANGLE_W-1:0]  cfg_wdata_i
);
  import vad_pkg::*;

  vad_cmd_t cmd;
  vad_sts_t sts;

  vad_ctrl #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (in_item_i.last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vad_datapath #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

/* sv/vad_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vad_checker
// port-level checks for the angular distance block
// ----------------------------------------------------------------------------
module vad_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_stall_o,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input vad_pkg::vad_out_t out_item_o
);
  import vad_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item changed");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.zero_norm |->
      (out_item_o.angle == '0) && !out_item_o.is_neighbour)
    else $error("zero vector item not cleared");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.angle <= PI_Q13)
    else $error("angle above pi");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("item without computation");

endmodule

bind vector_angular_distance vad_checker u_vad_checker (.*);
`default_nettype wire

/* tb/vector_angular_distance_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angular_distance_tb
// streams element pairs into the angular distance block, predicts each angle,
// neighbour and zero-length flag in fixed point and checks results in order,
// with random idling on both sides, a long output hold-off and limit changes
// ----------------------------------------------------------------------------
module vector_angular_distance_tb;
  import vad_pkg::*;

  localparam int unsigned MAXLEN     = 64;
  localparam int unsigned SETTLE_CYC = 200;
  localparam longint      CYCLE_CAP  = 3000000;
  localparam int          N_ITEMS    = 1250;

  localparam longint ATAN_TAB [21] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
    bit                 typed;
    vad_out_t           res;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  vad_in_t            in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  vad_out_t           out_item;
  logic               cfg_we = 1'b0;
  logic [ANGLE_W-1:0] cfg_wdata = '0;

  vad_out_t           angle_q[$];
  longint             dot_acc;
  longint unsigned    na_acc, nb_acc;
  int unsigned        pair_cnt;
  logic [ANGLE_W-1:0] limit_reg;
  int                 errs = 0;
  int                 sent = 0;
  int                 n_res = 0;
  int                 stall_left = 0;
  int                 hold_left = 0;
  bit                 calm = 0;
  longint             cycles = 0;

  vector_angular_distance #(.MAX_LENGTH(MAXLEN)) DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'h1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic longint shift_tz(input longint v, input int s);
    longint m;
    if (v >= 0) return v >>> s;
    m = -v;
    return -(m >>> s);
  endfunction

  function automatic logic [ANGLE_W-1:0] arc_angle(input bit neg,
      input longint unsigned n, input longint unsigned d);
    longint unsigned r, c, s;
    longint x, y, z, dx, dy;
    r = n;
    c = 0;
    z = 0;
    if (n >= d) return neg ? PI_Q13 : '0;
    for (int i = 0; i < 30; i++) begin
      r <<= 1;
      c <<= 1;
      if (r >= d) begin
        r -= d;
        c |= 1;
      end
    end
    s = int_sqrt((64'h1 << 60) - c * c);
    x = c;
    y = s;
    for (int i = 0; i < 21; i++) begin
      dx = shift_tz(y, i);
      dy = shift_tz(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else if (y < 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        break;
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI_Q20) z = HALF_PI_Q20;
    if (neg) z = PI_Q20 - z;
    z = (z + 64) >>> 7;
    if (z > PI_Q13) z = PI_Q13;
    return z[ANGLE_W-1:0];
  endfunction

  // accumulate one pair; on the final pair returns 1 with the expected result
  function automatic bit predict_angle(input vad_in_t it, output vad_out_t res);
    longint a, b;
    longint unsigned mag, ra, rb;
    bit neg;
    a = it.a_elem;
    b = it.b_elem;
    res = '0;
    dot_acc += a * b;
    na_acc += a * a;
    nb_acc += b * b;
    pair_cnt++;
    if (!it.last && pair_cnt < MAXLEN) return 0;
    if (na_acc == 0 || nb_acc == 0) begin
      res.zero_norm = 1'b1;
    end else begin
      neg = dot_acc < 0;
      mag = neg ? -dot_acc : dot_acc;
      ra = int_sqrt(na_acc << 20);
      rb = int_sqrt(nb_acc << 20);
      res.angle = arc_angle(neg, mag << 20, ra * rb);
      res.is_neighbour = res.angle <= limit_reg;
    end
    dot_acc = 0;
    na_acc = 0;
    nb_acc = 0;
    pair_cnt = 0;
    return 1;
  endfunction

  task automatic push_pair(input vad_in_t it, input bit typed, input vad_out_t tres);
    vad_out_t res;
    int gap;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sent++;
    if (predict_angle(it, res)) angle_q.push_back(typed ? tres : res);
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_vec(input int len, input int mode, input bit overlong);
    vad_in_t it;
    logic signed [15:0] a, b;
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (mode)
        1: begin a = $signed(a) >>> 10; b = $signed(b) >>> 10; end
        2: if ($urandom_range(0, 1)) a = '0; else b = '0;
        3: b = a;
        4: b = -a;
        5: b = a + $signed(b >>> 12);
        default: ;
      endcase
      it.a_elem = a;
      it.b_elem = b;
      it.last = overlong ? 1'b0 : (i == len - 1);
      push_pair(it, 0, '0);
    end
  endtask

  task automatic idle_and_write(input logic [ANGLE_W-1:0] val);
    in_valid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = val;
  endtask

  // output side: random stall per item plus one long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("vector_angular_distance_tb: FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (angle_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected item: %p", out_item);
      end else begin
        if (out_item !== angle_q[0]) begin
          errs++;
          if (errs <= 10) $display("mismatch: exp %p got %p", angle_q[0], out_item);
        end
        void'(angle_q.pop_front());
      end
      n_res++;
      if (n_res == 20) hold_left = 400;
      stall_left = calm ? 0 : $urandom_range(0, 14);
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (hold_left > 0) || (stall_left > 0);
  end

  initial begin
    row_t rows[$];
    row_t rw;
    logic [ANGLE_W-1:0] limits[6];
    int len, mode;
    dot_acc = 0;
    na_acc = 0;
    nb_acc = 0;
    pair_cnt = 0;
    limit_reg = LIMIT_RESET;
    limits = '{LIMIT_RESET, 15'd0, 15'd25736, 15'h7FFF, 15'd12868, 15'd0};
    limits[5] = 15'($urandom_range(0, 25736));

    // zero vector, parallel, antiparallel, extremes, orthogonal, mixed
    rows.push_back('{16'sd0, 16'sd5, 1'b1, 1, '{15'd0, 1'b0, 1'b1}});
    rows.push_back('{16'sd0, 16'sd0, 1'b1, 1, '{15'd0, 1'b0, 1'b1}});
    rows.push_back('{16'sd32767, 16'sd32767, 1'b1, 1, '{15'd0, 1'b1, 1'b0}});
    rows.push_back('{16'sd32767, -16'sd32768, 1'b1, 1, '{PI_Q13, 1'b1, 1'b0}});
    rows.push_back('{-16'sd32768, -16'sd32768, 1'b1, 1, '{15'd0, 1'b1, 1'b0}});
    rows.push_back('{-16'sd1, 16'sd1, 1'b1, 1, '{PI_Q13, 1'b1, 1'b0}});
    rows.push_back('{16'sd32767, 16'sd0, 1'b0, 0, '0});
    rows.push_back('{16'sd0, 16'sd32767, 1'b1, 0, '0});
    rows.push_back('{16'sd1000, 16'sd2000, 1'b0, 0, '0});
    rows.push_back('{-16'sd3000, 16'sd500, 1'b0, 0, '0});
    rows.push_back('{16'sd7, -16'sd32768, 1'b1, 0, '0});
    rows.push_back('{16'sd12345, 16'sd12000, 1'b0, 0, '0});
    rows.push_back('{16'sd100, 16'sd300, 1'b1, 0, '0});
    rows.push_back('{-16'sd32768, 16'sd32767, 1'b0, 0, '0});
    rows.push_back('{16'sd32767, -16'sd32768, 1'b0, 0, '0});
    rows.push_back('{16'sd1, 16'sd1, 1'b1, 0, '0});
    rows.push_back('{16'sd0, 16'sd0, 1'b0, 0, '0});
    rows.push_back('{16'sd0, -16'sd9, 1'b1, 1, '{15'd0, 1'b0, 1'b1}});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      rw = rows[i];
      push_pair('{rw.a, rw.b, rw.last}, rw.typed, rw.res);
    end
    // overlong vector closes itself at the length limit
    send_vec(MAXLEN, 0, 1);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) idle_and_write(limits[ph]);
      while (sent < (ph + 1) * N_ITEMS / 6) begin
        calm = ($urandom_range(0, 7) == 0);
        mode = $urandom_range(0, 5);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAXLEN) : $urandom_range(1, 8);
        send_vec(len, mode, $urandom_range(0, 39) == 0);
      end
      // close any open vector
      send_vec(1, 0, 0);
    end
    calm = 0;

    in_valid <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (errs == 0) begin
      $display("vector_angular_distance_tb: PASS");
    end else begin
      $display("vector_angular_distance_tb: FAIL");
    end
    $finish;
  end

endmodule
